FILE: rtl/ssm_pkg.sv
// shared types and constants of the shot sample metrics block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DIV_W   = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  // pressure<<8 over flow has at most 24 quotient bits
  localparam logic [DIV_CNT_W-1:0] RES_DIV_STEPS   = DIV_CNT_W'(24);
  localparam logic [DIV_CNT_W-1:0] DARCY_DIV_STEPS = DIV_CNT_W'(32);

  localparam int unsigned ACC_W = 42;

  localparam int unsigned DEF_SEGMENT_LIMIT = 255;
  localparam int unsigned DEF_QUEUE_DEPTH   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_FLOOR     = 8'd0,
    CFG_PRESSURE_FLOOR = 8'd1,
    CFG_RESISTANCE_CAP = 8'd2,
    CFG_DARCY_CAP      = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] flow_floor;
    logic [15:0] pressure_floor;
    logic [15:0] resistance_cap;
    logic [15:0] darcy_cap;
  } cfg_t;

  // one classified sample handed from front to back
  typedef struct packed {
    logic [15:0] pressure;
    logic [15:0] flow;
    logic        res_en;
    logic        darcy_en;
    logic [31:0] water_total;
    logic [7:0]  pressure_seg;
    logic [7:0]  flow_seg;
    logic        pressure_kept;
    logic        flow_kept;
    logic [31:0] latest_time;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/ssm_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on ssm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssm_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [ssm_pkg::DIV_CNT_W-1:0]  steps_i,
  input  wire logic [ssm_pkg::DIV_W-1:0]      dividend_i,
  input  wire logic [ssm_pkg::DIV_W-1:0]      divisor_i,
  output logic                                done_o,
  output logic [ssm_pkg::DIV_W-1:0]           quotient_o
);
  import ssm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIV_W-1:0]     dsr_q;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/ssm_fifo.sv
// small queue of classified samples between front and back
// depends on ssm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssm_fifo #(
  parameter int unsigned DEPTH = ssm_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ssm_pkg::entry_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ssm_pkg::entry_t      pop_data_o,
  output logic                 empty_o
);
  import ssm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic do_push;
  logic do_pop;

  assign full_o  = cnt_q == FULL_CNT;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/ssm_front.sv
// front end: accepts samples, gates resistances, updates water, segments and time
// depends on ssm_pkg; feeds ssm_fifo
`timescale 1ns / 1ps
`default_nettype none

module ssm_front #(
  parameter int unsigned SEGMENT_LIMIT = ssm_pkg::DEF_SEGMENT_LIMIT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ssm_pkg::cfg_t                     cfg_i,
  input  wire logic                              s_valid_i,
  output logic                                   s_ready_o,
  // time[31:0], pressure[47:32], flow[63:48], pressure goal[79:64], flow goal[95:80]
  input  wire logic [ssm_pkg::IN_TDATA_W-1:0]    s_data_i,
  // flow_mode[0]
  input  wire logic [ssm_pkg::IN_TUSER_W-1:0]    s_user_i,
  output logic                                   push_o,
  output ssm_pkg::entry_t                        push_data_o,
  input  wire logic                              full_i
);
  import ssm_pkg::*;

  localparam logic [7:0] SEG_MAX = (SEGMENT_LIMIT > 255) ? 8'd255 : 8'(SEGMENT_LIMIT);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ACC
  } front_state_e;

  front_state_e state_q;

  // architectural state
  logic [ACC_W-1:0] acc_q;
  logic [31:0]      prev_time_q;
  logic             seen_q;
  logic             prev_mode_q;
  logic [7:0]       pseg_q;
  logic [7:0]       fseg_q;
  logic [31:0]      max_time_q;

  // per-sample payload
  logic [15:0] p_q;
  logic [15:0] f_q;
  logic        res_en_q;
  logic        darcy_en_q;
  logic        pkept_q;
  logic        fkept_q;
  logic        adv_q;
  logic [31:0] dt_q;
  logic [47:0] inc_q;

  logic [31:0] t;
  logic [15:0] p;
  logic [15:0] f;
  logic [15:0] pt;
  logic [15:0] ft;
  logic        mode;
  logic        accept;
  logic [ACC_W+6:0] sum;
  logic [ACC_W-1:0] acc_d;

  assign t    = s_data_i[31:0];
  assign p    = s_data_i[47:32];
  assign f    = s_data_i[63:48];
  assign pt   = s_data_i[79:64];
  assign ft   = s_data_i[95:80];
  assign mode = s_user_i[0];

  assign s_ready_o = state_q == F_IDLE;
  assign accept    = s_valid_i && s_ready_o;

  // saturating add of the water increment
  assign sum   = {7'b0, acc_q} + {1'b0, inc_q};
  assign acc_d = !adv_q ? acc_q : ((|sum[ACC_W+6:ACC_W]) ? '1 : sum[ACC_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      acc_q       <= '0;
      prev_time_q <= '0;
      seen_q      <= 1'b0;
      prev_mode_q <= 1'b0;
      pseg_q      <= '0;
      fseg_q      <= '0;
      max_time_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            prev_time_q <= t;
            prev_mode_q <= mode;
            seen_q      <= 1'b1;
            if (seen_q && mode != prev_mode_q) begin
              if (mode) begin
                if (pseg_q < SEG_MAX) pseg_q <= pseg_q + 8'd1;
              end else begin
                if (fseg_q < SEG_MAX) fseg_q <= fseg_q + 8'd1;
              end
            end
            if (t > max_time_q) max_time_q <= t;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          state_q <= F_ACC;
        end
        F_ACC: begin
          if (!full_i) begin
            acc_q   <= acc_d;
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q        <= p;
      f_q        <= f;
      res_en_q   <= f > cfg_i.flow_floor;
      darcy_en_q <= (f > cfg_i.flow_floor) && (p > cfg_i.pressure_floor);
      pkept_q    <= pt != 16'd0;
      fkept_q    <= ft != 16'd0;
      adv_q      <= seen_q && (t > prev_time_q);
      dt_q       <= t - prev_time_q;
    end
    if (state_q == F_MUL) begin
      inc_q <= 48'(f_q) * 48'(dt_q);
    end
  end

  assign push_o = (state_q == F_ACC) && !full_i;

  always_comb begin
    push_data_o.pressure      = p_q;
    push_data_o.flow          = f_q;
    push_data_o.res_en        = res_en_q;
    push_data_o.darcy_en      = darcy_en_q;
    push_data_o.water_total   = acc_d[ACC_W-1:10];
    push_data_o.pressure_seg  = pseg_q;
    push_data_o.flow_seg      = fseg_q;
    push_data_o.pressure_kept = pkept_q;
    push_data_o.flow_kept     = fkept_q;
    push_data_o.latest_time   = max_time_q;
  end

endmodule

`default_nettype wire

FILE: rtl/ssm_back.sv
// back end: the two divisions, clamping and the output register
// depends on ssm_pkg and ssm_div; reads from ssm_fifo
`timescale 1ns / 1ps
`default_nettype none

module ssm_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ssm_pkg::cfg_t                     cfg_i,
  output logic                                   pop_o,
  input  wire ssm_pkg::entry_t                   pop_data_i,
  input  wire logic                              empty_i,
  output logic                                   m_valid_o,
  input  wire logic                              m_ready_i,
  output logic [ssm_pkg::OUT_TDATA_W-1:0]        m_data_o,
  output logic [ssm_pkg::OUT_TUSER_W-1:0]        m_user_o
);
  import ssm_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_RES,
    B_DARCY,
    B_OUT
  } back_state_e;

  back_state_e state_q;

  entry_t      ent_q;
  logic [31:0] fsq_q;
  logic [15:0] res_q;
  logic [15:0] darcy_q;

  logic                        m_valid_q;
  logic [OUT_TDATA_W-1:0]      m_data_q;
  logic [OUT_TUSER_W-1:0]      m_user_q;

  logic                 div_start;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [15:0]          res_clamped;
  logic [15:0]          darcy_clamped;
  logic                 out_free;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_free = !m_valid_q || m_ready_i;

  // both dividends are pressure<<16; the resistance division runs 24 steps
  always_comb begin
    div_start    = 1'b0;
    div_steps    = RES_DIV_STEPS;
    div_dividend = {ent_q.pressure, 16'b0};
    div_divisor  = {16'b0, ent_q.flow};
    if (state_q == B_LOAD) begin
      div_start = ent_q.res_en;
    end else if (state_q == B_RES) begin
      div_start   = div_done && ent_q.darcy_en;
      div_steps   = DARCY_DIV_STEPS;
      div_divisor = fsq_q;
    end
  end

  ssm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign res_clamped   = (div_quo > {16'b0, cfg_i.resistance_cap}) ?
                         cfg_i.resistance_cap : div_quo[15:0];
  assign darcy_clamped = (div_quo > {16'b0, cfg_i.darcy_cap}) ?
                         cfg_i.darcy_cap : div_quo[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (m_ready_i) m_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!empty_i) state_q <= B_LOAD;
        end
        B_LOAD: begin
          state_q <= ent_q.res_en ? B_RES : B_OUT;
        end
        B_RES: begin
          if (div_done) state_q <= ent_q.darcy_en ? B_DARCY : B_OUT;
        end
        B_DARCY: begin
          if (div_done) state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= pop_data_i;
    case (state_q)
      B_LOAD: begin
        fsq_q   <= 32'(ent_q.flow) * 32'(ent_q.flow);
        res_q   <= '0;
        darcy_q <= '0;
      end
      B_RES: begin
        if (div_done) res_q <= res_clamped;
      end
      B_DARCY: begin
        if (div_done) darcy_q <= darcy_clamped;
      end
      B_OUT: begin
        if (out_free) begin
          m_data_q <= {ent_q.latest_time, ent_q.flow_seg, ent_q.pressure_seg,
                       ent_q.water_total, darcy_q, res_q};
          m_user_q <= {ent_q.flow_kept, ent_q.pressure_kept};
        end
      end
      default: begin
      end
    endcase
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

endmodule

`default_nettype wire

FILE: rtl/shot_sample_metrics.sv
// a sample runs through front states F_IDLE, F_MUL, F_ACC, the queue, then back states
// B_IDLE, B_LOAD, B_RES, B_DARCY (each division only when enabled) and B_OUT, held by stalls;
// the divisions share one radix-2 divider; the back starts a sample once the last is out
// reset: asynchronous active low; config returns to its defaults (13, 13, 3840, 4864),
// water, segment indices, times and the queue are cleared; no clearing pass
// depends on ssm_pkg, ssm_front, ssm_fifo, ssm_back, ssm_div
`timescale 1ns / 1ps
`default_nettype none

module shot_sample_metrics #(
  parameter int unsigned SEGMENT_LIMIT = ssm_pkg::DEF_SEGMENT_LIMIT,
  parameter int unsigned QUEUE_DEPTH   = ssm_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  // configuration writes, always ready
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0]    cfg_data_i,

  // sample input
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // sample_time[31:0], pressure_in[47:32], flow_in[63:48],
  // pressure_target[79:64], flow_target[95:80]
  input  wire logic [ssm_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // flow_mode[0]
  input  wire logic [ssm_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,

  // metrics output
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // resistance_out[15:0], darcy_out[31:16], water_total[63:32],
  // pressure_goal_segment[71:64], flow_goal_segment[79:72], latest_time[111:80]
  output logic [ssm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // pressure_goal_kept[0], flow_goal_kept[1]
  output logic [ssm_pkg::OUT_TUSER_W-1:0]        m_axis_tuser_o
);
  import ssm_pkg::*;

  cfg_t   cfg_q;
  logic   push;
  entry_t push_data;
  logic   full;
  logic   pop;
  entry_t pop_data;
  logic   empty;

  // register file; writes to unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_floor     <= 16'd13;
      cfg_q.pressure_floor <= 16'd13;
      cfg_q.resistance_cap <= 16'd3840;
      cfg_q.darcy_cap      <= 16'd4864;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FLOW_FLOOR:     cfg_q.flow_floor     <= cfg_data_i;
        CFG_PRESSURE_FLOOR: cfg_q.pressure_floor <= cfg_data_i;
        CFG_RESISTANCE_CAP: cfg_q.resistance_cap <= cfg_data_i;
        CFG_DARCY_CAP:      cfg_q.darcy_cap      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front: takes a sample, gates the resistances, runs water and segment state
  ssm_front #(
    .SEGMENT_LIMIT (SEGMENT_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // short queue so the front keeps taking samples while divisions run
  ssm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // back: divisions, clamping, output register
  ssm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o),
    .m_user_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb_shot_sample_metrics.sv
// self-checking testbench for shot_sample_metrics: directed table, then random samples
// under several register settings, each result checked against hand values or a
// cycle-free predictor; depends on ssm_pkg and the shot_sample_metrics rtl
`timescale 1ns / 1ps

module tb_shot_sample_metrics;
  import ssm_pkg::*;

  localparam int unsigned SEG_CEIL = (DEF_SEGMENT_LIMIT > 255) ? 255 : DEF_SEGMENT_LIMIT;
  localparam logic [41:0] WATER_MAX = {42{1'b1}};
  localparam logic [15:0] DEF_FLOOR     = 16'd13;
  localparam logic [15:0] DEF_RES_CAP   = 16'd3840;
  localparam logic [15:0] DEF_DARCY_CAP = 16'd4864;
  localparam logic [CFG_IDX_W-1:0] CFG_BOGUS_INDEX = 8'hFF;
  localparam int unsigned PHASES         = 5;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned REPORT_LINES   = 50;

  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] pressure;
    logic [15:0] flow;
    logic [15:0] p_goal;
    logic [15:0] f_goal;
    logic        flow_ctl;
  } sample_t;

  typedef struct packed {
    logic [15:0] resistance;
    logic [15:0] darcy;
    logic [31:0] water;
    logic [7:0]  p_seg;
    logic [7:0]  f_seg;
    logic        p_kept;
    logic        f_kept;
    logic [31:0] latest;
  } metrics_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_SETTINGS,
    ROW_STRAY_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    sample_t     smp;
    bit          typed;
    metrics_t    want;
    logic [15:0] ff;
    logic [15:0] pf;
    logic [15:0] rc;
    logic [15:0] dc;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_valid   = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data    = '0;
  logic [IN_TUSER_W-1:0]  s_user    = '0;
  logic                   m_valid;
  logic                   m_ready   = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [OUT_TUSER_W-1:0] m_user;

  // predictor copy of the registers and the block state
  logic [15:0] flow_floor_q     = DEF_FLOOR;
  logic [15:0] pressure_floor_q = DEF_FLOOR;
  logic [15:0] res_cap_q        = DEF_RES_CAP;
  logic [15:0] darcy_cap_q      = DEF_DARCY_CAP;
  logic [41:0] water_acc   = '0;
  logic [31:0] last_time   = '0;
  logic        have_sample = 1'b0;
  logic        last_mode   = 1'b0;
  logic [7:0]  pseg_idx    = '0;
  logic [7:0]  fseg_idx    = '0;
  logic [31:0] peak_time   = '0;

  metrics_t    pending_metrics[$];
  int unsigned mismatches    = 0;
  bit          idle_on       = 1'b1;
  bit          long_hold_due = 1'b0;

  shot_sample_metrics #(
    .SEGMENT_LIMIT(DEF_SEGMENT_LIMIT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // advances the predictor by one accepted sample and returns the metrics it gives
  function automatic metrics_t predict_metrics(input sample_t s);
    metrics_t    m;
    logic [63:0] ratio;
    logic [63:0] inc;
    m = '0;
    if (s.flow > flow_floor_q) begin
      ratio = 64'({s.pressure, 8'd0}) / 64'(s.flow);
      m.resistance = (ratio > 64'(res_cap_q)) ? res_cap_q : ratio[15:0];
      if (s.pressure > pressure_floor_q) begin
        ratio = 64'({s.pressure, 16'd0}) / (64'(s.flow) * 64'(s.flow));
        m.darcy = (ratio > 64'(darcy_cap_q)) ? darcy_cap_q : ratio[15:0];
      end
    end
    // water only grows when time moves forward after the first sample
    if (have_sample && s.stamp > last_time) begin
      inc = 64'(s.flow) * 64'(s.stamp - last_time);
      if (inc > 64'(WATER_MAX - water_acc)) water_acc = WATER_MAX;
      else water_acc = water_acc + inc[41:0];
    end
    last_time = s.stamp;
    if (have_sample && s.flow_ctl != last_mode) begin
      if (s.flow_ctl) pseg_idx = (pseg_idx < SEG_CEIL) ? pseg_idx + 8'd1 : pseg_idx;
      else fseg_idx = (fseg_idx < SEG_CEIL) ? fseg_idx + 8'd1 : fseg_idx;
    end
    last_mode = s.flow_ctl;
    have_sample = 1'b1;
    if (s.stamp > peak_time) peak_time = s.stamp;
    m.water  = water_acc[41:10];
    m.p_seg  = pseg_idx;
    m.f_seg  = fseg_idx;
    m.p_kept = (s.p_goal != 16'd0);
    m.f_kept = (s.f_goal != 16'd0);
    m.latest = peak_time;
    return m;
  endfunction

  function automatic logic [15:0] draw_level(input logic [15:0] floor_q);
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom());
      2: return 16'($urandom_range(0, 31));
      3: return floor_q + 16'($urandom_range(0, 2)) - 16'd1;
      4: return 16'($urandom_range(16'h0080, 16'h1000));
      default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
    endcase
  endfunction

  // mostly small forward time steps; some repeats, some steps back, rare far jumps
  function automatic sample_t draw_sample(input bit toggle_mode);
    sample_t     s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    s.pressure = draw_level(pressure_floor_q);
    s.flow     = draw_level(flow_floor_q);
    if (pick < 2) begin
      // far jump: low flow keeps the water total clear of saturation
      s.stamp = $urandom();
      s.flow  = 16'($urandom_range(0, 3));
    end else if (pick < 8) begin
      s.stamp = $urandom_range(0, last_time);
    end else if (pick < 14) begin
      s.stamp = last_time;
    end else begin
      s.stamp = last_time + 32'($urandom_range(1, 2047));
    end
    s.p_goal = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom());
    s.f_goal = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom());
    s.flow_ctl = (toggle_mode || $urandom_range(0, 7) != 0) ? ~last_mode : last_mode;
    return s;
  endfunction

  function automatic stim_row_t sample_row(input logic [31:0] t, input logic [15:0] p,
                                           input logic [15:0] f, input logic [15:0] pg,
                                           input logic [15:0] fg, input logic mode);
    stim_row_t r;
    r.kind  = ROW_SAMPLE;
    r.smp   = {t, p, f, pg, fg, mode};
    r.typed = 1'b0;
    r.want  = '0;
    r.ff    = '0;
    r.pf    = '0;
    r.rc    = '0;
    r.dc    = '0;
    return r;
  endfunction

  function automatic stim_row_t settings_row(input logic [15:0] ff, input logic [15:0] pf,
                                             input logic [15:0] rc, input logic [15:0] dc);
    stim_row_t r;
    r      = sample_row('0, '0, '0, '0, '0, 1'b0);
    r.kind = ROW_SETTINGS;
    r.ff   = ff;
    r.pf   = pf;
    r.rc   = rc;
    r.dc   = dc;
    return r;
  endfunction

  function automatic metrics_t mk_metrics(input logic [15:0] res, input logic [15:0] darcy,
                                          input logic [31:0] water, input logic [7:0] pseg,
                                          input logic [7:0] fseg, input logic pk,
                                          input logic fk, input logic [31:0] latest);
    return {res, darcy, water, pseg, fseg, pk, fk, latest};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_LINES)
      $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_sample(input sample_t smp, input bit typed, input metrics_t want);
    int unsigned gap;
    metrics_t    model;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {smp.f_goal, smp.p_goal, smp.flow, smp.pressure, smp.stamp};
    s_user  = smp.flow_ctl;
    do @(posedge clk_i); while (!s_ready);
    model = predict_metrics(smp);
    pending_metrics.push_back(typed ? want : model);
    @(negedge clk_i);
  endtask

  // stop offering samples and wait until every result is back
  task automatic settle();
    s_valid = 1'b0;
    do @(negedge clk_i); while (pending_metrics.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_FLOW_FLOOR:     flow_floor_q     = val;
      CFG_PRESSURE_FLOOR: pressure_floor_q = val;
      CFG_RESISTANCE_CAP: res_cap_q        = val;
      CFG_DARCY_CAP:      darcy_cap_q      = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] ff, input logic [15:0] pf,
                               input logic [15:0] rc, input logic [15:0] dc);
    settle();
    write_reg(CFG_FLOW_FLOOR, ff);
    write_reg(CFG_PRESSURE_FLOOR, pf);
    write_reg(CFG_RESISTANCE_CAP, rc);
    write_reg(CFG_DARCY_CAP, dc);
    cfg_valid = 1'b0;
  endtask

  task automatic run_rows(input stim_row_t rows[$]);
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_SAMPLE: push_sample(rows[i].smp, rows[i].typed, rows[i].want);
        ROW_SETTINGS: load_settings(rows[i].ff, rows[i].pf, rows[i].rc, rows[i].dc);
        default: begin
          // index past the register file: the write must change nothing
          settle();
          write_reg(CFG_BOGUS_INDEX, rows[i].ff);
          cfg_valid = 1'b0;
        end
      endcase
    end
  endtask

  task automatic check_metrics();
    metrics_t got;
    metrics_t want;
    got.resistance = m_data[15:0];
    got.darcy      = m_data[31:16];
    got.water      = m_data[63:32];
    got.p_seg      = m_data[71:64];
    got.f_seg      = m_data[79:72];
    got.latest     = m_data[111:80];
    got.p_kept     = m_user[0];
    got.f_kept     = m_user[1];
    if (pending_metrics.size() == 0) begin
      report_mismatch("result with nothing pending, water_total", got.water, '0);
    end else begin
      want = pending_metrics.pop_front();
      if (got.resistance !== want.resistance)
        report_mismatch("resistance_out", got.resistance, want.resistance);
      if (got.darcy !== want.darcy) report_mismatch("darcy_out", got.darcy, want.darcy);
      if (got.water !== want.water) report_mismatch("water_total", got.water, want.water);
      if (got.p_seg !== want.p_seg)
        report_mismatch("pressure_goal_segment", got.p_seg, want.p_seg);
      if (got.f_seg !== want.f_seg)
        report_mismatch("flow_goal_segment", got.f_seg, want.f_seg);
      if (got.p_kept !== want.p_kept)
        report_mismatch("pressure_goal_kept", got.p_kept, want.p_kept);
      if (got.f_kept !== want.f_kept)
        report_mismatch("flow_goal_kept", got.f_kept, want.f_kept);
      if (got.latest !== want.latest)
        report_mismatch("latest_time", got.latest, want.latest);
    end
  endtask

  // result side: random stalls per transfer, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        m_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        m_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready = 1'b1;
      do @(posedge clk_i); while (!m_valid);
      check_metrics();
      @(negedge clk_i);
    end
  end

  // ends the run when no transfer of any kind happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   opening_rows[$];
    stim_row_t   closing_rows[$];
    stim_row_t   r;
    int unsigned extra;

    // first sample, then one second at 2 ml/s and 9 bar: all values plain by hand
    r = sample_row(32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    r.typed = 1'b1;
    r.want  = mk_metrics('0, '0, '0, '0, '0, 1'b0, 1'b0, '0);
    opening_rows.push_back(r);
    r = sample_row(32'd1024, 16'h0900, 16'h0200, 16'h0900, 16'd0, 1'b0);
    r.typed = 1'b1;
    r.want  = mk_metrics(16'h0480, 16'h0240, 32'h200, '0, '0, 1'b1, 1'b0, 32'd1024);
    opening_rows.push_back(r);
    // flow equal to its floor, then just above it with capped results and a mode change
    opening_rows.push_back(sample_row(32'd2048, 16'h0900, DEF_FLOOR, 16'd0, 16'h0180, 1'b0));
    opening_rows.push_back(sample_row(32'd2048, 16'hFFFF, DEF_FLOOR + 16'd1, 16'd0, 16'd0,
                                      1'b1));
    // time going backward, pressure equal to its floor, mode back to pressure control
    opening_rows.push_back(sample_row(32'd1500, DEF_FLOOR, 16'h0300, 16'd0, 16'd0, 1'b0));
    opening_rows.push_back(sample_row(32'd3000, DEF_FLOOR + 16'd1, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 1'b0));
    opening_rows.push_back(sample_row(32'd4000, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 1'b1));
    // floors at zero, caps at the top
    opening_rows.push_back(settings_row(16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
    opening_rows.push_back(sample_row(32'd5000, 16'hFFFF, 16'd1, 16'd0, 16'd1, 1'b1));
    opening_rows.push_back(sample_row(32'd6000, 16'd1, 16'hFFFF, 16'd0, 16'd0, 1'b0));
    opening_rows.push_back(sample_row(32'd6001, 16'd0, 16'd1, 16'd0, 16'd0, 1'b1));
    // caps of zero force both results to zero
    opening_rows.push_back(settings_row(16'd0, 16'd0, 16'd0, 16'd0));
    opening_rows.push_back(sample_row(32'd7000, 16'h0100, 16'h0100, 16'd0, 16'd0, 1'b1));
    r = settings_row(16'hFFFF, 16'd0, 16'd0, 16'd0);
    r.kind = ROW_STRAY_WRITE;
    opening_rows.push_back(r);
    opening_rows.push_back(sample_row(32'd8000, 16'h0100, 16'h0100, 16'd0, 16'd0, 1'b0));
    // floors at the top gate everything off
    opening_rows.push_back(settings_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    opening_rows.push_back(sample_row(32'd9000, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0));
    opening_rows.push_back(sample_row(32'd9000, 16'h8000, 16'h8000, 16'd0, 16'd0, 1'b1));
    opening_rows.push_back(settings_row(DEF_FLOOR, DEF_FLOOR, DEF_RES_CAP, DEF_DARCY_CAP));
    opening_rows.push_back(sample_row(32'd10240, 16'h0200, 16'h0100, 16'd1, 16'h8000, 1'b1));

    // the water overflow and the top sample time come last, as both stick until reset
    closing_rows.push_back(settings_row(DEF_FLOOR, DEF_FLOOR, DEF_RES_CAP, DEF_DARCY_CAP));
    closing_rows.push_back(sample_row(32'd0, 16'h0100, 16'd0, 16'd0, 16'd0, 1'b1));
    r = sample_row(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    r.typed = 1'b1;
    r.want  = mk_metrics(16'd256, 16'd1, 32'hFFFF_FFFF, 8'(SEG_CEIL), 8'(SEG_CEIL), 1'b1,
                         1'b1, 32'hFFFF_FFFF);
    closing_rows.push_back(r);
    closing_rows.push_back(sample_row(32'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0));
    closing_rows.push_back(sample_row(32'd100, DEF_FLOOR, 16'hFFFF, 16'd0, 16'd0, 1'b1));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_rows(opening_rows);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph != 2);
      case (ph)
        0: load_settings(DEF_FLOOR, DEF_FLOOR, DEF_RES_CAP, DEF_DARCY_CAP);
        1: load_settings(16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
                         16'($urandom()), 16'($urandom()));
        2: load_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        3: load_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()));
        default: load_settings(16'($urandom_range(0, 16)), 16'($urandom_range(0, 16)),
                               16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
      endcase
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // long output hold-off while samples keep coming, so the input backs up
        if (ph == 1 && k == 20) long_hold_due = 1'b1;
        if (ph == 3 && k == 50) settle();
        push_sample(draw_sample(1'b0), 1'b0, '0);
      end
    end

    // keep toggling the mode until both segment counters sit at their ceiling
    idle_on = 1'b1;
    extra = 0;
    while (pseg_idx < SEG_CEIL || fseg_idx < SEG_CEIL || extra < 6) begin
      if (pseg_idx == SEG_CEIL && fseg_idx == SEG_CEIL) extra++;
      push_sample(draw_sample(1'b1), 1'b0, '0);
    end

    run_rows(closing_rows);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
